[src/julia_escape_time_pixel_assert.svh]
// ----------------------------------------------------------------------------
// julia escape time pixel assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

// same-cycle implication
`define JETP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JETP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/jetp_pkg.sv]
// ----------------------------------------------------------------------------
// jetp_pkg
// types, register indexes and saturation helpers for the julia pixel block
// ----------------------------------------------------------------------------
package jetp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 10;
    localparam int COUNT_W    = 8;
    localparam int Q_FRAC     = 28;

    localparam logic [CFG_ADDR_W-1:0] REG_CONST_RE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONST_IM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_RE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_IM   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_RE  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_IM  = 3'd5;

    localparam logic signed [31:0] RST_CONST_RE = -32'sd195124485;
    localparam logic signed [31:0] RST_CONST_IM = 32'sd50704004;
    localparam logic signed [31:0] RST_LEFT_RE  = -32'sd268435456;
    localparam logic signed [31:0] RST_TOP_IM   = 32'sd268435456;
    localparam logic [30:0]        RST_STEP_RE  = 31'd838861;
    localparam logic [30:0]        RST_STEP_IM  = 31'd1118481;

    // 4.0 in q8.56
    localparam logic [63:0] ESCAPE_LIMIT = 64'd1 << (2 * Q_FRAC + 2);

    typedef struct packed {
        logic signed [31:0] const_re;
        logic signed [31:0] const_im;
        logic signed [31:0] left_re;
        logic signed [31:0] top_im;
        logic [30:0]        step_re;
        logic [30:0]        step_im;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] a0;
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] b1;
        logic signed [31:0] a2;
        logic signed [31:0] b2;
    } mul_ops_t;

    typedef struct packed {
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
    } mul_prod_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

[src/julia_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// escape-time count for one pixel of a julia set, q4.28 fixed point
//
// input stream s_*: one word per pixel, column and row. output stream m_*:
// one word per pixel, the iteration count. the user must write the constant,
// region corner and steps on the cfg_* port while the block is idle; the
// block does not enforce this. a shared three-multiplier unit is used for
// the grid point and then once per iteration; each iteration runs through
// the multiply, the square and escape test, and the constant add. s_tready
// stays low from the time a pixel is taken until its result is raised, and
// the next pixel can be taken once the block is back in its idle state.
// the result sits in an output register; the block
// takes the next pixel while it waits, and only holds its last step if a
// new result is ready before the old one is taken.
// reset restores the default constants and empties the output register.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_assert.svh"

module julia_escape_time_pixel
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int MAX_ITER = 255
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // col[9:0], row[19:10], zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // iteration_count[7:0]
    input  logic                               cfg_we,
    input  logic [jetp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CW = jetp_pkg::COORD_W;
    localparam logic [jetp_pkg::COUNT_W-1:0] ITER_LIMIT = jetp_pkg::COUNT_W'(MAX_ITER);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRID_MUL,
        ST_GRID_ADD,
        ST_MUL,
        ST_SQR,
        ST_ADD
    } state_t;

    state_t                          state_reg, state_next;
    logic signed [31:0]              re_reg, re_next;
    logic signed [31:0]              im_reg, im_next;
    logic signed [31:0]              nre_reg, nre_next;
    logic signed [31:0]              nim_reg, nim_next;
    logic [jetp_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [jetp_pkg::COUNT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [CW-1:0]                   row_reg, row_next;

    jetp_pkg::cfg_t                  cfg;
    jetp_pkg::mul_ops_t              ops;
    jetp_pkg::mul_prod_t             prod;
    logic                            mul_en;

    logic [CW-1:0]                   col_in, row_in;
    logic signed [63:0]              diff, diff_sh, cross_sh;
    logic [63:0]                     mag;
    logic                            done;
    logic                            out_free;

    jetp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jetp_cmul u_cmul
    (
        .clk  (clk),
        .en   (mul_en),
        .ops  (ops),
        .prod (prod)
    );

    // clamp to the grid
    always_comb
    begin
        col_in = s_tdata[CW-1:0];
        row_in = s_tdata[2*CW-1:CW];
        if (int'(col_in) > MAX_COLS - 1)
            col_in = CW'(MAX_COLS - 1);
        if (int'(row_in) > MAX_ROWS - 1)
            row_in = CW'(MAX_ROWS - 1);
    end

    // operand select for the shared multipliers
    always_comb
    begin
        mul_en = (state_reg == ST_GRID_MUL) || (state_reg == ST_MUL);
        if (state_reg == ST_GRID_MUL)
        begin
            ops.a0 = $signed({{(32-CW){1'b0}}, col_reg});
            ops.b0 = $signed({1'b0, cfg.step_re});
            ops.a1 = $signed({{(32-CW){1'b0}}, row_reg});
            ops.b1 = $signed({1'b0, cfg.step_im});
            ops.a2 = '0;
            ops.b2 = '0;
        end
        else
        begin
            ops.a0 = re_reg;
            ops.b0 = re_reg;
            ops.a1 = im_reg;
            ops.b1 = im_reg;
            ops.a2 = re_reg;
            ops.b2 = im_reg;
        end
    end

    // square, escape test
    always_comb
    begin
        diff     = prod.p0 - prod.p1;
        diff_sh  = diff >>> jetp_pkg::Q_FRAC;
        cross_sh = prod.p2 >>> (jetp_pkg::Q_FRAC - 1);
        mag      = 64'(prod.p0) + 64'(prod.p1);
        done     = (count_reg >= ITER_LIMIT) || (mag > jetp_pkg::ESCAPE_LIMIT);
        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb
    begin
        state_next    = state_reg;
        re_next       = re_reg;
        im_next       = im_reg;
        nre_next      = nre_reg;
        nim_next      = nim_reg;
        count_next    = count_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    col_next   = col_in;
                    row_next   = row_in;
                    state_next = ST_GRID_MUL;
                end
            end
            ST_GRID_MUL:
            begin
                state_next = ST_GRID_ADD;
            end
            ST_GRID_ADD:
            begin
                re_next    = jetp_pkg::sat64(64'(cfg.left_re) + prod.p0);
                im_next    = jetp_pkg::sat64(64'(cfg.top_im) - prod.p1);
                count_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (done)
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = count_reg;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    nre_next   = jetp_pkg::sat64(diff_sh);
                    nim_next   = jetp_pkg::sat64(cross_sh);
                    count_next = count_reg + 1'b1;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                re_next    = jetp_pkg::sat_add(nre_reg, cfg.const_re);
                im_next    = jetp_pkg::sat_add(nim_reg, cfg.const_im);
                state_next = ST_MUL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            re_reg       <= '0;
            im_reg       <= '0;
            nre_reg      <= '0;
            nim_reg      <= '0;
            count_reg    <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            re_reg       <= re_next;
            im_reg       <= im_next;
            nre_reg      <= nre_next;
            nim_reg      <= nim_next;
            count_reg    <= count_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `JETP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
                      "block still ready after taking a word")
    `JETP_ASSERT_NOW(a_count_bound, 1'b1, int'(count_reg) <= MAX_ITER,
                     "iteration count beyond limit")
    `JETP_ASSERT_NOW(a_add_after_step, state_reg == ST_ADD, count_reg != '0,
                     "constant add without a counted step")
    `JETP_ASSERT_NOW(a_result_from_test, $rose(m_tvalid), $past(state_reg == ST_SQR),
                     "result word not raised by escape test")

endmodule

[src/jetp_cfg.sv]
// ----------------------------------------------------------------------------
// jetp_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module jetp_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [jetp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output jetp_pkg::cfg_t                     cfg
);

    jetp_pkg::cfg_t cfg_reg;
    jetp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                jetp_pkg::REG_CONST_RE: cfg_next.const_re = $signed(cfg_wdata);
                jetp_pkg::REG_CONST_IM: cfg_next.const_im = $signed(cfg_wdata);
                jetp_pkg::REG_LEFT_RE:  cfg_next.left_re  = $signed(cfg_wdata);
                jetp_pkg::REG_TOP_IM:   cfg_next.top_im   = $signed(cfg_wdata);
                jetp_pkg::REG_STEP_RE:  cfg_next.step_re  = cfg_wdata[30:0];
                jetp_pkg::REG_STEP_IM:  cfg_next.step_im  = cfg_wdata[30:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.const_re <= jetp_pkg::RST_CONST_RE;
            cfg_reg.const_im <= jetp_pkg::RST_CONST_IM;
            cfg_reg.left_re  <= jetp_pkg::RST_LEFT_RE;
            cfg_reg.top_im   <= jetp_pkg::RST_TOP_IM;
            cfg_reg.step_re  <= jetp_pkg::RST_STEP_RE;
            cfg_reg.step_im  <= jetp_pkg::RST_STEP_IM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/jetp_cmul.sv]
// ----------------------------------------------------------------------------
// jetp_cmul
// shared multiplier unit, three signed 32x32 products registered on enable
// ----------------------------------------------------------------------------
module jetp_cmul
(
    input  logic                  clk,
    input  logic                  en,
    input  jetp_pkg::mul_ops_t    ops,
    output jetp_pkg::mul_prod_t   prod
);

    jetp_pkg::mul_prod_t prod_reg;
    jetp_pkg::mul_prod_t prod_next;

    always_comb
    begin
        prod_next.p0 = $signed(ops.a0) * $signed(ops.b0);
        prod_next.p1 = $signed(ops.a1) * $signed(ops.b1);
        prod_next.p2 = $signed(ops.a2) * $signed(ops.b2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[sim/tb_julia_escape_time_pixel.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel
// self-checking bench for the julia escape-time pixel block. a table of
// register writes and pixels covers the corner cases first, then phases of
// random regions and pixels follow, with random stalls on both streams. every
// count is checked in order against a table value or q4.28 escape-time model.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel;

    localparam int          ITER_CAP     = 255;
    localparam int          FRAC         = 28;
    localparam int          ONE_Q28      = 268435456;
    localparam logic [63:0] RADIUS_SQ    = 64'd1 << 58;
    localparam longint      SAT_HI       = 64'sd2147483647;
    localparam longint      SAT_LO       = -64'sd2147483648;
    localparam logic [jetp_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [jetp_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int          NO_COUNT     = -1;
    localparam int          LONG_HOLD    = 2000;
    localparam int          DRAIN        = 1000;
    localparam int          RAND_PHASES  = 9;
    localparam int          PHASE_PIXELS = 50;
    localparam longint      CYCLE_LIMIT  = 2000000;

    typedef struct {
        bit                              wr;
        logic [jetp_pkg::CFG_ADDR_W-1:0] idx;
        logic [31:0]                     val;
        logic [9:0]                      col;
        logic [9:0]                      row;
        int                              want;
    } plan_row_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata   = '0;    // col[9:0], row[19:10], zero
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;           // iteration_count[7:0]
    logic                            cfg_we    = 1'b0;
    logic [jetp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [jetp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic signed [31:0] c_re   = jetp_pkg::RST_CONST_RE;
    logic signed [31:0] c_im   = jetp_pkg::RST_CONST_IM;
    logic signed [31:0] org_re = jetp_pkg::RST_LEFT_RE;
    logic signed [31:0] org_im = jetp_pkg::RST_TOP_IM;
    logic [30:0]        inc_re = jetp_pkg::RST_STEP_RE;
    logic [30:0]        inc_im = jetp_pkg::RST_STEP_IM;

    logic [7:0]  count_q [$];
    logic [7:0]  want_cnt;
    int          mismatches  = 0;
    longint      cycles      = 0;
    bit          calm        = 1'b0;
    bit          hold_req    = 1'b0;
    int          tx_idle_pct = 10;
    int          rx_idle_pct = 10;
    int          rx_gap      = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    plan_row_t   plan [$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    julia_escape_time_pixel i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic longint clip32(input longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    function automatic logic [7:0] escape_count(input logic [9:0] col, input logic [9:0] row);
        longint      re;
        longint      im;
        longint      nre;
        longint      nim;
        logic [63:0] mag;
        int          n;
        re = clip32(longint'(org_re) + longint'(col) * longint'(inc_re));
        im = clip32(longint'(org_im) - longint'(row) * longint'(inc_im));
        n  = 0;
        while (n < ITER_CAP)
        begin
            mag = 64'(re * re) + 64'(im * im);
            if (mag > RADIUS_SQ)
                break;
            // floor shifts, z*z back to q4.28
            nre = clip32((re * re - im * im) >>> FRAC);
            nim = clip32((re * im) >>> (FRAC - 1));
            re  = clip32(nre + longint'(c_re));
            im  = clip32(nim + longint'(c_im));
            n++;
        end
        return 8'(n);
    endfunction

    function automatic plan_row_t plan_write(input logic [jetp_pkg::CFG_ADDR_W-1:0] idx,
                                             input logic [31:0] val);
        plan_row_t r;
        r.wr   = 1'b1;
        r.idx  = idx;
        r.val  = val;
        r.col  = '0;
        r.row  = '0;
        r.want = NO_COUNT;
        return r;
    endfunction

    function automatic plan_row_t plan_pixel(input logic [9:0] col, input logic [9:0] row,
                                             input int want);
        plan_row_t r;
        r.wr   = 1'b0;
        r.idx  = jetp_pkg::REG_CONST_RE;
        r.val  = '0;
        r.col  = col;
        r.row  = row;
        r.want = want;
        return r;
    endfunction

    task automatic write_reg(input logic [jetp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        unique case (idx)
            jetp_pkg::REG_CONST_RE: c_re   = val;
            jetp_pkg::REG_CONST_IM: c_im   = val;
            jetp_pkg::REG_LEFT_RE:  org_re = val;
            jetp_pkg::REG_TOP_IM:   org_im = val;
            jetp_pkg::REG_STEP_RE:  inc_re = val[30:0];
            jetp_pkg::REG_STEP_IM:  inc_im = val[30:0];
            default: ;
        endcase
    endtask

    // stop offering and wait for every pending count
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (count_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [9:0] col, input logic [9:0] row, input int want);
        int gap;
        cfg_we <= 1'b0;
        if (!calm && $urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(17, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        count_q.push_back(want < 0 ? escape_count(col, row) : 8'(want));
    endtask

    task automatic flag_mismatch(input int want, input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (want < 0)
                $display("cycle %0d: count word %0d with none pending", cycles, got);
            else
                $display("cycle %0d: count expected %0d, got %0d", cycles, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // count word checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (count_q.size() == 0)
                flag_mismatch(NO_COUNT, m_tdata);
            else
            begin
                want_cnt = count_q.pop_front();
                if (m_tdata !== want_cnt)
                    flag_mismatch(want_cnt, m_tdata);
            end
        end
    end

    // receiver: random idle bursts plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_gap    <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (rx_gap != 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end
        else if (!calm && $urandom_range(99) < rx_idle_pct)
        begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(16, 0);
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin : stimulus
        int          ph;
        int          k;
        int          mode;
        int          idle_choice [3];
        logic [31:0] v_const_re;
        logic [31:0] v_const_im;
        logic [31:0] v_left;
        logic [31:0] v_top;
        logic [31:0] v_step_re;
        logic [31:0] v_step_im;
        logic [31:0] corner [4];

        idle_choice = '{0, 8, 30};
        plan = {
            // reset region
            plan_pixel(10'd0,    10'd0,    NO_COUNT),
            plan_pixel(10'd1023, 10'd1023, NO_COUNT),
            plan_pixel(10'd1023, 10'd0,    NO_COUNT),
            plan_pixel(10'd0,    10'd1023, NO_COUNT),
            plan_pixel(10'd512,  10'd480,  NO_COUNT),
            // all zero: z stays at the origin
            plan_write(jetp_pkg::REG_CONST_RE, 32'd0),
            plan_write(jetp_pkg::REG_CONST_IM, 32'd0),
            plan_write(jetp_pkg::REG_LEFT_RE,  32'd0),
            plan_write(jetp_pkg::REG_TOP_IM,   32'd0),
            plan_write(jetp_pkg::REG_STEP_RE,  32'd0),
            plan_write(jetp_pkg::REG_STEP_IM,  32'd0),
            plan_pixel(10'd1023, 10'd1023, ITER_CAP),
            // start exactly on the radius-2 circle, then just outside it and at both extremes
            plan_write(jetp_pkg::REG_LEFT_RE,  32'h2000_0000),
            plan_pixel(10'd0,    10'd0,    1),
            plan_write(jetp_pkg::REG_LEFT_RE,  32'h2000_0001),
            plan_pixel(10'd5,    10'd5,    0),
            plan_write(jetp_pkg::REG_LEFT_RE,  32'h7fff_ffff),
            plan_pixel(10'd0,    10'd0,    0),
            plan_write(jetp_pkg::REG_LEFT_RE,  32'h8000_0000),
            plan_pixel(10'd0,    10'd0,    0),
            // extreme constant, escapes after one step
            plan_write(jetp_pkg::REG_LEFT_RE,  32'd0),
            plan_write(jetp_pkg::REG_CONST_RE, 32'h7fff_ffff),
            plan_write(jetp_pkg::REG_CONST_IM, 32'h8000_0000),
            plan_pixel(10'd0,    10'd0,    1),
            // grid point saturation
            plan_write(jetp_pkg::REG_CONST_RE, 32'd0),
            plan_write(jetp_pkg::REG_CONST_IM, 32'd0),
            plan_write(jetp_pkg::REG_STEP_RE,  32'h7fff_ffff),
            plan_pixel(10'd1023, 10'd0,    0),
            plan_pixel(10'd1,    10'd0,    0),
            plan_write(jetp_pkg::REG_STEP_RE,  32'd0),
            plan_write(jetp_pkg::REG_STEP_IM,  32'h7fff_ffff),
            plan_pixel(10'd0,    10'd1023, 0),
            // unused indexes must leave the zero region alone
            plan_write(jetp_pkg::REG_STEP_IM,  32'd0),
            plan_write(REG_SPARE_LO, 32'hffff_ffff),
            plan_write(REG_SPARE_HI, 32'h1234_5678),
            plan_pixel(10'd0,    10'd0,    ITER_CAP),
            // saturation inside the iteration
            plan_write(jetp_pkg::REG_LEFT_RE,  32'h16a0_9e66),
            plan_write(jetp_pkg::REG_TOP_IM,   32'h16a0_9e66),
            plan_write(jetp_pkg::REG_CONST_IM, 32'h7fff_ffff),
            plan_pixel(10'd0,    10'd0,    NO_COUNT),
            plan_write(jetp_pkg::REG_CONST_RE, 32'h8000_0000),
            plan_write(jetp_pkg::REG_CONST_IM, 32'h8000_0000),
            plan_pixel(10'd0,    10'd0,    NO_COUNT),
            // ordinary julia region
            plan_write(jetp_pkg::REG_CONST_RE, -32'sd214748365),
            plan_write(jetp_pkg::REG_CONST_IM, 32'sd41875931),
            plan_write(jetp_pkg::REG_LEFT_RE,  -32'sd402653184),
            plan_write(jetp_pkg::REG_TOP_IM,   32'sd268435456),
            plan_write(jetp_pkg::REG_STEP_RE,  32'd786432),
            plan_write(jetp_pkg::REG_STEP_IM,  32'd524288),
            plan_pixel(10'd512,  10'd512,  NO_COUNT),
            plan_pixel(10'd300,  10'd700,  NO_COUNT),
            plan_pixel(10'd1023, 10'd1023, NO_COUNT),
            plan_pixel(10'd0,    10'd0,    NO_COUNT)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_pixel(plan[i].col, plan[i].row, plan[i].want);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            mode = $urandom_range(9);
            if (mode == 0)
            begin
                v_const_re = $urandom();
                v_const_im = $urandom();
                v_left     = $urandom();
                v_top      = $urandom();
                v_step_re  = $urandom();
                v_step_im  = $urandom();
            end
            else if (mode == 1)
            begin
                corner     = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, $urandom()};
                v_const_re = corner[$urandom_range(3)];
                v_const_im = corner[$urandom_range(3)];
                v_left     = corner[$urandom_range(3)];
                v_top      = corner[$urandom_range(3)];
                v_step_re  = corner[$urandom_range(3)];
                v_step_im  = corner[$urandom_range(3)];
            end
            else
            begin
                // c in [-1, 0.5] x [-1, 1], corner in [-2, -1] x [1, 2]
                v_const_re = int'($urandom_range(3 * ONE_Q28 / 2)) - ONE_Q28;
                v_const_im = int'($urandom_range(2 * ONE_Q28)) - ONE_Q28;
                v_left     = -int'($urandom_range(ONE_Q28)) - ONE_Q28;
                v_top      = int'($urandom_range(ONE_Q28)) + ONE_Q28;
                v_step_re  = $urandom_range(ONE_Q28 / 128, ONE_Q28 / 1024);
                v_step_im  = $urandom_range(ONE_Q28 / 128, ONE_Q28 / 1024);
            end
            write_reg(jetp_pkg::REG_CONST_RE, v_const_re);
            write_reg(jetp_pkg::REG_CONST_IM, v_const_im);
            write_reg(jetp_pkg::REG_LEFT_RE,  v_left);
            write_reg(jetp_pkg::REG_TOP_IM,   v_top);
            write_reg(jetp_pkg::REG_STEP_RE,  v_step_re);
            write_reg(jetp_pkg::REG_STEP_IM,  v_step_im);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());

            tx_idle_pct <= idle_choice[$urandom_range(2)];
            rx_idle_pct <= idle_choice[$urandom_range(2)];
            if (ph == 1)
                hold_req <= 1'b1;
            if (ph == RAND_PHASES - 1)
                calm <= 1'b1;

            for (k = 0; k < PHASE_PIXELS; k++)
                send_pixel($urandom_range(1023), $urandom_range(1023), NO_COUNT);
        end

        wait_drained();
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0 && count_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/jetp_pkg.sv
src/jetp_cfg.sv
src/jetp_cmul.sv
src/julia_escape_time_pixel.sv
sim/tb_julia_escape_time_pixel.sv
